// ===== rtl/sprr_pkg.sv =====
// ----------------------------------------------------------------------------
// sprr_pkg
// Shared constants, codes and controller/datapath interface types for the
// 8x16 sprite row renderer.
// ----------------------------------------------------------------------------
package sprr_pkg;

    localparam int PATTERN_COUNT = 256;
    localparam int SPRITE_ROWS   = 16;
    localparam int STORE_DEPTH   = 4096;
    localparam int ADDR_W        = 12;
    localparam int PIX_W         = 3;
    localparam int ROW_PIXELS    = 8;
    localparam int ROW_DATA_W    = PIX_W * ROW_PIXELS;
    localparam int ROW_W         = $clog2(SPRITE_ROWS);
    localparam int POS_W         = 11;
    localparam int SIZE_W        = 10;
    localparam int CFG_IDX_W     = 2;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SPRITE_ROWS - 1);

    localparam int SY_BASE  = 240;
    localparam int SX_BASE  = 248;
    localparam int X_OFFSET = 2;
    localparam int Y_OFFSET = 17;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(224);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FLIP_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

    typedef struct packed {
        logic             load;
        logic             start;
        logic             issue;
        logic [ROW_W-1:0] row;
    } t_dp_cmd;

    typedef struct packed {
        logic s1_free;
    } t_dp_sts;

endpackage

// ===== rtl/sprr_ram.sv =====
// ----------------------------------------------------------------------------
// sprr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sprr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sprr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sprr_ctrl
// Controller: accepts words, sequences the sixteen row reads of a draw.
// ----------------------------------------------------------------------------
module sprr_ctrl
    import sprr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_cmd,
    output logic    o_ready,
    output t_dp_cmd o_dp_cmd,
    input  t_dp_sts i_dp_sts
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DRAW = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_DRAW) begin
                    n_state = S_DRAW;
                    n_row   = '0;
                end
            end
            S_DRAW: begin
                if (i_dp_sts.s1_free) begin
                    n_row = r_row + ROW_W'(1);
                    if (r_row == ROW_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_dp_cmd.load  = accept && (i_cmd == CMD_LOAD);
        o_dp_cmd.start = accept && (i_cmd == CMD_DRAW);
        o_dp_cmd.issue = (r_state == S_DRAW) && i_dp_sts.s1_free;
        o_dp_cmd.row   = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

`ifndef SYNTHESIS
    a_last_row_ends_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW && i_dp_sts.s1_free && r_row == ROW_LAST)
        |=> (r_state == S_IDLE))
        else $error("draw did not end after last row");

    a_draw_starts_at_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.start |=> (r_state == S_DRAW && r_row == '0))
        else $error("draw did not start at row zero");

    a_no_issue_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.issue |-> !o_ready)
        else $error("row read issued while accepting words");
`endif

endmodule

// ===== rtl/sprr_dp.sv =====
// ----------------------------------------------------------------------------
// sprr_dp
// Datapath: registers, pattern store, row fetch, flip and clipping mask,
// output register.
// ----------------------------------------------------------------------------
module sprr_dp
    import sprr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_dp_cmd,
    output t_dp_sts                o_dp_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    input  logic [ADDR_W-1:0]      i_pattern_address,
    input  logic [ROW_DATA_W-1:0]  i_pattern_row,
    input  logic [7:0]             i_sprite_y_byte,
    input  logic [7:0]             i_sprite_code,
    input  logic [7:0]             i_sprite_attr,
    input  logic [7:0]             i_sprite_x_byte,
    input  logic                   i_list_start,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [8:0]      o_row_y,
    output logic signed [9:0]      o_start_x,
    output logic [ROW_DATA_W-1:0]  o_row_pixels,
    output logic [ROW_PIXELS-1:0]  o_write_mask,
    output logic                   o_last_row
);

    // configuration
    logic              r_flip_screen;
    logic              r_first_flip_y;
    logic [SIZE_W-1:0] r_screen_width;
    logic [SIZE_W-1:0] r_screen_height;

    // per-draw parameters
    logic              r_prev_flip_y;
    logic [7:0]        r_code;
    logic [POS_W-1:0]  r_y0, n_y0;
    logic [POS_W-1:0]  r_x0, n_x0;
    logic              r_fx, r_fy;

    // fetch stage
    logic              r_s1_vld;
    logic [POS_W-1:0]  r_s1_y;
    logic [POS_W-1:0]  r_s1_x;
    logic              r_s1_fx;
    logic              r_s1_last;

    // output stage
    logic                  r_out_vld;
    logic [8:0]            r_out_y;
    logic [9:0]            r_out_x;
    logic [ROW_DATA_W-1:0] r_out_pix, n_out_pix;
    logic [ROW_PIXELS-1:0] r_out_mask, n_out_mask;
    logic                  r_out_last;

    logic                  out_free;
    logic                  s1_adv;
    logic [ROW_W-1:0]      src_row;
    logic [ADDR_W-1:0]     ram_addr;
    logic [ROW_DATA_W-1:0] ram_rdata;
    logic                  y_ok;
    logic [POS_W-1:0]      xx;

    assign out_free         = !r_out_vld || i_ready;
    assign s1_adv           = r_s1_vld && out_free;
    assign o_dp_sts.s1_free = !r_s1_vld || out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_screen   <= 1'b0;
            r_first_flip_y  <= 1'b0;
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FLIP_SCREEN:   r_flip_screen   <= i_cfg_data[0];
                REG_FIRST_FLIP_Y:  r_first_flip_y  <= i_cfg_data[0];
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sprite position, flip screen mirrors both axes
    always_comb begin
        if (r_flip_screen) begin
            n_y0 = POS_W'(i_sprite_y_byte) - POS_W'(Y_OFFSET);
            n_x0 = POS_W'(SX_BASE + X_OFFSET) - POS_W'(i_sprite_x_byte);
        end else begin
            n_y0 = POS_W'(SY_BASE - Y_OFFSET) - POS_W'(i_sprite_y_byte);
            n_x0 = POS_W'(i_sprite_x_byte) + POS_W'(X_OFFSET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_flip_y <= 1'b0;
        end else if (i_dp_cmd.start) begin
            r_prev_flip_y <= i_sprite_attr[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_code <= i_sprite_code;
            r_y0   <= n_y0;
            r_x0   <= n_x0;
            r_fx   <= i_sprite_attr[6] ^ r_flip_screen;
            r_fy   <= (i_list_start ? r_first_flip_y : r_prev_flip_y) ^ r_flip_screen;
        end
    end

    // pattern store
    assign src_row  = r_fy ? (ROW_LAST - i_dp_cmd.row) : i_dp_cmd.row;
    assign ram_addr = i_dp_cmd.load ? i_pattern_address
                    : ADDR_W'(ADDR_W'(r_code) * ADDR_W'(SPRITE_ROWS) + ADDR_W'(src_row));

    sprr_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.load),
        .i_re    (i_dp_cmd.issue),
        .i_addr  (ram_addr),
        .i_wdata (i_pattern_row),
        .o_rdata (ram_rdata)
    );

    // fetch stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_dp_cmd.issue) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.issue) begin
            r_s1_y    <= r_y0 + POS_W'(i_dp_cmd.row);
            r_s1_x    <= r_x0;
            r_s1_fx   <= r_fx;
            r_s1_last <= (i_dp_cmd.row == ROW_LAST);
        end
    end

    // horizontal flip and clipping mask
    always_comb begin
        y_ok = !r_s1_y[POS_W-1] && (r_s1_y < POS_W'(r_screen_height));
        xx   = '0;
        for (int i = 0; i < ROW_PIXELS; i++) begin
            if (r_s1_fx) begin
                n_out_pix[PIX_W*i +: PIX_W] = ram_rdata[PIX_W*(ROW_PIXELS-1-i) +: PIX_W];
            end else begin
                n_out_pix[PIX_W*i +: PIX_W] = ram_rdata[PIX_W*i +: PIX_W];
            end
            xx = r_s1_x + POS_W'(i);
            n_out_mask[i] = (n_out_pix[PIX_W*i +: PIX_W] != '0) && y_ok
                          && !xx[POS_W-1] && (xx < POS_W'(r_screen_width));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_y    <= r_s1_y[8:0];
            r_out_x    <= r_s1_x[9:0];
            r_out_pix  <= n_out_pix;
            r_out_mask <= n_out_mask;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_row_y      = $signed(r_out_y);
    assign o_start_x    = $signed(r_out_x);
    assign o_row_pixels = r_out_pix;
    assign o_write_mask = r_out_mask;
    assign o_last_row   = r_out_last;

`ifndef SYNTHESIS
    a_stalled_fetch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_ready) |=> (r_s1_vld && $stable(r_s1_y)))
        else $error("fetch stage lost a row under stall");

    a_no_store_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_dp_cmd.load && i_dp_cmd.issue))
        else $error("store written and read in one cycle");

    a_issue_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.issue |-> (!r_s1_vld || out_free))
        else $error("row read issued into a full fetch stage");
`endif

endmodule

// ===== rtl/sprite_row_renderer_8x16.sv =====
// ----------------------------------------------------------------------------
// sprite_row_renderer_8x16
// Load command: one word per cycle, written to the pattern store.
// Draw command: no new word is taken until the last of its rows is issued;
// sixteen row reads through the single store port, one per cycle unless the
// output stalls; row words leave via the fetch stage and output register.
// Reset: synchronous, active low; pattern store is not cleared.
// ----------------------------------------------------------------------------
module sprite_row_renderer_8x16
    import sprr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_cmd,
    input  logic [ADDR_W-1:0]      i_pattern_address,
    input  logic [ROW_DATA_W-1:0]  i_pattern_row,
    input  logic [7:0]             i_sprite_y_byte,
    input  logic [7:0]             i_sprite_code,
    input  logic [7:0]             i_sprite_attr,
    input  logic [7:0]             i_sprite_x_byte,
    input  logic                   i_list_start,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [8:0]      o_row_y,
    output logic signed [9:0]      o_start_x,
    output logic [ROW_DATA_W-1:0]  o_row_pixels,
    output logic [ROW_PIXELS-1:0]  o_write_mask,
    output logic                   o_last_row,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    sprr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_ready  (o_ready),
        .o_dp_cmd (dp_cmd),
        .i_dp_sts (dp_sts)
    );

    sprr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_sts          (dp_sts),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pattern_address (i_pattern_address),
        .i_pattern_row     (i_pattern_row),
        .i_sprite_y_byte   (i_sprite_y_byte),
        .i_sprite_code     (i_sprite_code),
        .i_sprite_attr     (i_sprite_attr),
        .i_sprite_x_byte   (i_sprite_x_byte),
        .i_list_start      (i_list_start),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_row_y           (o_row_y),
        .o_start_x         (o_start_x),
        .o_row_pixels      (o_row_pixels),
        .o_write_mask      (o_write_mask),
        .o_last_row        (o_last_row)
    );

endmodule

// ===== verif/sprite_row_renderer_8x16_tb.sv =====
// ----------------------------------------------------------------------------
// sprite_row_renderer_8x16_tb
// Self-checking bench for the 8x16 sprite row renderer. Pattern rows are
// loaded and sprite entries drawn through the input channel while the four
// registers are set between phases. A behavioural model in the bench works out
// the sixteen row words of each draw, and every output word is checked field
// by field, in order, against them. Both channels idle at random.
// ----------------------------------------------------------------------------
module sprite_row_renderer_8x16_tb;
    import sprr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [8:0]            row_y;
        logic [9:0]            start_x;
        logic [ROW_DATA_W-1:0] pixels;
        logic [ROW_PIXELS-1:0] mask;
        logic                  last;
    } t_row_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_cmd;
    logic [ADDR_W-1:0]     i_pattern_address;
    logic [ROW_DATA_W-1:0] i_pattern_row;
    logic [7:0]            i_sprite_y_byte;
    logic [7:0]            i_sprite_code;
    logic [7:0]            i_sprite_attr;
    logic [7:0]            i_sprite_x_byte;
    logic                  i_list_start;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [8:0]     o_row_y;
    logic signed [9:0]     o_start_x;
    logic [ROW_DATA_W-1:0] o_row_pixels;
    logic [ROW_PIXELS-1:0] o_write_mask;
    logic                  o_last_row;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [SIZE_W-1:0]     i_cfg_data;

    // model state
    logic [ROW_DATA_W-1:0] pattern_mem [STORE_DEPTH];
    int                    loaded_codes[$];
    logic                  prev_flip_y;
    logic                  flip_screen_reg;
    logic                  first_flip_y_reg;
    int                    scr_width;
    int                    scr_height;
    t_row_word             rows_due[$];

    int n_errors;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_stall_left;

    sprite_row_renderer_8x16 dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(99) < rx_idle_pct) begin
            rx_stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40) - 1
                                                     : $urandom_range(1, 3) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_rows
        t_row_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (rows_due.size() == 0) begin
                $error("row word with nothing expected");
                n_errors++;
            end else begin
                want = rows_due.pop_front();
                if (o_row_y !== want.row_y) begin
                    $error("row_y: expected %0d, got %0d", $signed(want.row_y), o_row_y);
                    n_errors++;
                end
                if (o_start_x !== want.start_x) begin
                    $error("start_x: expected %0d, got %0d", $signed(want.start_x),
                           o_start_x);
                    n_errors++;
                end
                if (o_row_pixels !== want.pixels) begin
                    $error("row_pixels: expected %h, got %h", want.pixels, o_row_pixels);
                    n_errors++;
                end
                if (o_write_mask !== want.mask) begin
                    $error("write_mask: expected %b, got %b", want.mask, o_write_mask);
                    n_errors++;
                end
                if (o_last_row !== want.last) begin
                    $error("last_row: expected %b, got %b", want.last, o_last_row);
                    n_errors++;
                end
            end
        end
    end

    task automatic render_sprite_rows(input logic [7:0] yb, input logic [7:0] code,
                                      input logic [7:0] attr, input logic [7:0] xb,
                                      input logic start);
        int        sx, sy, x0, y0, yy, xx, srow, addr, r, i;
        logic      fx, fy;
        logic [2:0] pix;
        logic [ROW_DATA_W-1:0] src;
        t_row_word w;
        sx = int'(xb);
        sy = 240 - int'(yb);
        fx = attr[6];
        fy = start ? first_flip_y_reg : prev_flip_y;
        prev_flip_y = attr[7];
        if (flip_screen_reg) begin
            sx = 248 - sx;
            sy = 240 - sy;
            fx = ~fx;
            fy = ~fy;
        end
        x0 = sx + 2;
        y0 = sy - 17;
        for (r = 0; r < SPRITE_ROWS; r++) begin
            yy = y0 + r;
            srow = fy ? SPRITE_ROWS - 1 - r : r;
            addr = ((int'(code) % PATTERN_COUNT) * SPRITE_ROWS + srow) % STORE_DEPTH;
            src = pattern_mem[addr];
            w.row_y = 9'(yy);
            w.start_x = 10'(x0);
            w.pixels = '0;
            w.mask = '0;
            w.last = (r == SPRITE_ROWS - 1);
            for (i = 0; i < ROW_PIXELS; i++) begin
                pix = fx ? src[3*(7-i) +: 3] : src[3*i +: 3];
                w.pixels[3*i +: 3] = pix;
                xx = x0 + i;
                if (pix != 0 && yy >= 0 && yy < scr_height && xx >= 0 && xx < scr_width)
                    w.mask[i] = 1'b1;
            end
            rows_due.push_back(w);
        end
    endtask

    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [ROW_DATA_W-1:0] row, input logic [7:0] yb,
                             input logic [7:0] code, input logic [7:0] attr,
                             input logic [7:0] xb, input logic start);
        int gap;
        i_valid           <= 1'b1;
        i_cmd             <= cmd;
        i_pattern_address <= addr;
        i_pattern_row     <= row;
        i_sprite_y_byte   <= yb;
        i_sprite_code     <= code;
        i_sprite_attr     <= attr;
        i_sprite_x_byte   <= xb;
        i_list_start      <= start;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == CMD_LOAD) begin
            pattern_mem[addr] = row;
        end else begin
            render_sprite_rows(yb, code, attr, xb, start);
        end
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_row(input int addr, input logic [ROW_DATA_W-1:0] row);
        send_word(CMD_LOAD, ADDR_W'(addr), row, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic load_pattern(input int code);
        int r;
        logic [ROW_DATA_W-1:0] row;
        for (r = 0; r < SPRITE_ROWS; r++) begin
            row = ($urandom_range(7) == 0) ? '0 : ROW_DATA_W'($urandom);
            load_row(code * SPRITE_ROWS + r, row);
        end
        if (!(code inside {loaded_codes}))
            loaded_codes.push_back(code);
    endtask

    task automatic draw(input int yb, input int code, input int attr, input int xb,
                        input logic start);
        send_word(CMD_DRAW, ADDR_W'($urandom), ROW_DATA_W'($urandom), 8'(yb), 8'(code),
                  8'(attr), 8'(xb), start);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= SIZE_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FLIP_SCREEN:   flip_screen_reg = value[0];
            REG_FIRST_FLIP_Y:  first_flip_y_reg = value[0];
            REG_SCREEN_WIDTH:  scr_width = value & 'h3ff;
            REG_SCREEN_HEIGHT: scr_height = value & 'h3ff;
        endcase
    endtask

    task automatic set_config(input int flip, input int first_fy, input int width,
                              input int height);
        wait_idle();
        write_reg(REG_FLIP_SCREEN, flip);
        write_reg(REG_FIRST_FLIP_Y, first_fy);
        write_reg(REG_SCREEN_WIDTH, width);
        write_reg(REG_SCREEN_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_pattern_load();
        int r;
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        // blank row, full row and a ramp, the rest random
        load_row(0, '0);
        load_row(1, '1);
        load_row(2, 24'hfac688);
        for (r = 3; r < SPRITE_ROWS; r++)
            load_row(r, ROW_DATA_W'($urandom));
        loaded_codes.push_back(0);
        load_pattern(255);
    endtask

    task automatic test_flip_chain();
        // default registers, vertical flip handed on from entry to entry
        draw(100, 0, 'h00, 50, 1'b1);
        draw(100, 0, 'h80, 60, 1'b0);
        draw(100, 255, 'h40, 70, 1'b0);
        draw(100, 255, 'hc0, 80, 1'b1);
        draw(100, 0, 'h3f, 90, 1'b0);
    endtask

    task automatic test_position_extremes();
        draw(0, 255, 'hff, 0, 1'b0);
        draw(255, 0, 'h00, 255, 1'b0);
        draw(16, 0, 'h00, 250, 1'b1);
        draw(232, 255, 'h7f, 0, 1'b0);
    endtask

    task automatic test_flip_screen();
        set_config(1, 1, 256, 224);
        draw(0, 0, 'h00, 0, 1'b1);
        draw(255, 255, 'h80, 255, 1'b0);
        draw(120, 0, 'h40, 128, 1'b0);
        draw(200, 255, 'hc0, 8, 1'b1);
    endtask

    task automatic test_clip_sizes();
        // one-pixel screen, sprite placed on the origin
        set_config(1, 0, 1, 1);
        draw(17, 0, 'h00, 250, 1'b1);
        draw(17, 255, 'h40, 250, 1'b0);
        set_config(0, 1, 512, 512);
        draw(0, 255, 'h80, 255, 1'b1);
        draw(255, 0, 'h40, 0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int phase, count, pick, code;
        for (phase = 0; phase < 5; phase++) begin
            set_config($urandom_range(1), $urandom_range(1),
                       ($urandom_range(3) == 0) ? 1 : ($urandom_range(2) == 0) ? 512
                                                : $urandom_range(1, 512),
                       ($urandom_range(3) == 0) ? 1 : ($urandom_range(2) == 0) ? 512
                                                : $urandom_range(1, 512));
            tx_idle_pct = (phase == 0) ? 0 : $urandom_range(10, 40);
            rx_idle_pct = (phase == 0) ? 0 : $urandom_range(10, 40);
            count = 0;
            while (count < 40) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    load_pattern($urandom_range(255));
                    count += SPRITE_ROWS;
                end else if (pick < 16) begin
                    load_row($urandom_range(STORE_DEPTH - 1), ROW_DATA_W'($urandom));
                    count++;
                end else begin
                    code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
                    draw($urandom_range(255), code, $urandom_range(255), $urandom_range(255),
                         $urandom_range(7) == 0);
                    count++;
                end
                // in phase 2, hold off until the output side has caught up
                if (phase == 2 && count >= 25 && count < 27)
                    wait_idle();
            end
        end
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_cmd             = CMD_LOAD;
        i_pattern_address = '0;
        i_pattern_row     = '0;
        i_sprite_y_byte   = '0;
        i_sprite_code     = '0;
        i_sprite_attr     = '0;
        i_sprite_x_byte   = '0;
        i_list_start      = 1'b0;
        i_ready           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_FLIP_SCREEN;
        i_cfg_data        = '0;
        prev_flip_y       = 1'b0;
        flip_screen_reg   = 1'b0;
        first_flip_y_reg  = 1'b0;
        scr_width         = 256;
        scr_height        = 224;
        n_errors          = 0;
        cycle_count       = 0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        rx_stall_left     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pattern_load();
        test_flip_chain();
        test_position_extremes();
        test_flip_screen();
        test_clip_sizes();
        test_random_traffic();
        wait_idle();

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sprr_pkg.sv
rtl/sprr_ram.sv
rtl/sprr_ctrl.sv
rtl/sprr_dp.sv
rtl/sprite_row_renderer_8x16.sv
verif/sprite_row_renderer_8x16_tb.sv
